[src/lpr_pkg.sv]
// ---------------------------------------------------------------------------
// lpr_pkg
// Shared types, widths and codes of the line pixel rasterizer.
// ---------------------------------------------------------------------------
package lpr_pkg;

    localparam int COORD_BITS = 11;
    localparam int ADDR_BITS  = 22;

    // signed working width of the current point
    localparam int SCOORD_BITS = COORD_BITS + 1;
    // width that holds panel_width*py+px and the largest valid address plus one
    localparam int PROD_BITS   = 2 * COORD_BITS + 1;
    localparam int ACC_BITS    = (PROD_BITS > ADDR_BITS) ? PROD_BITS : ADDR_BITS + 1;

    localparam logic [ACC_BITS-1:0] ADDR_MAX = ACC_BITS'((64'd1 << ADDR_BITS) - 64'd1);

    localparam int PADDR_BITS = 4;
    localparam int PDATA_BITS = 32;

    localparam logic [1:0] REG_ORIENTATION  = 2'd0;
    localparam logic [1:0] REG_PANEL_WIDTH  = 2'd1;
    localparam logic [1:0] REG_PANEL_HEIGHT = 2'd2;

    localparam logic                  ORIENT_RESET = 1'b1;
    localparam logic [COORD_BITS-1:0] WIDTH_RESET  = COORD_BITS'(800);
    localparam logic [COORD_BITS-1:0] HEIGHT_RESET = COORD_BITS'(480);

    localparam logic ORIENT_PORTRAIT = 1'b0;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef enum logic [1:0] {
        DIR_NONE  = 2'd0,
        DIR_PLUS  = 2'd1,
        DIR_MINUS = 2'd3
    } dir_t;

    // request as held in the input register
    typedef struct packed {
        logic                  cmd;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
        logic [15:0]           color;
    } req_t;

    // mapped pixel between the stepping stage and the address stage
    typedef struct packed {
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic                  off;
        logic                  last;
        logic [15:0]           color;
    } map_t;

    function automatic logic [SCOORD_BITS-1:0] advance(input logic [SCOORD_BITS-1:0] c,
                                                       input dir_t dir);
        logic [SCOORD_BITS-1:0] r;
        case (dir)
            DIR_PLUS:  r = c + SCOORD_BITS'(1);
            DIR_MINUS: r = c - SCOORD_BITS'(1);
            default:   r = c;
        endcase
        return r;
    endfunction

endpackage

[src/line_pixel_rasterizer_unit.sv]
// ---------------------------------------------------------------------------
// line_pixel_rasterizer_unit
// Error-accumulator line rasterizer: a start request loads a line; while it is
// loaded, each step yields one framebuffer pixel write with its mapped address.
// ---------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  req       in   req_valid/req_stall  cmd, x_start, y_start, x_end, y_end, line_color
//  pix       out  pix_valid/pix_stall  pixel_addr, pixel_color, off_panel, last_pixel
//  apb       in   psel/penable/pready  paddr, pwrite, pwdata, prdata
//
//  One request per cycle sustained unless req_stall is raised; a step passes
//  the input register, stepping/mapping register and address register.
//  The address stage holds the single panel_width*py multiply.
//  Empty pipeline stages close up under pix_stall; req_stall rises only when
//  all three stages hold work and the output is stalled.
//  Reset clears the line state and loads landscape, 800 x 480.
// ---------------------------------------------------------------------------
module line_pixel_rasterizer_unit
    import lpr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  req_valid,
    output logic                  req_stall,
    input  logic                  cmd,
    input  logic [COORD_BITS-1:0] x_start,
    input  logic [COORD_BITS-1:0] y_start,
    input  logic [COORD_BITS-1:0] x_end,
    input  logic [COORD_BITS-1:0] y_end,
    input  logic [15:0]           line_color,

    output logic                  pix_valid,
    input  logic                  pix_stall,
    output logic [ADDR_BITS-1:0]  pixel_addr,
    output logic [15:0]           pixel_color,
    output logic                  off_panel,
    output logic                  last_pixel,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_BITS-1:0] paddr,
    input  logic [PDATA_BITS-1:0] pwdata,
    output logic [PDATA_BITS-1:0] prdata,
    output logic                  pready
);

    // configuration
    logic                  orientation_reg;
    logic [COORD_BITS-1:0] panel_width_reg;
    logic [COORD_BITS-1:0] panel_height_reg;
    logic                  cfg_write;
    logic [1:0]            cfg_index;

    // line state
    logic [SCOORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic [SCOORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic [SCOORD_BITS-1:0] err_x_reg, err_x_next;
    logic [SCOORD_BITS-1:0] err_y_reg, err_y_next;
    logic [COORD_BITS-1:0]  abs_dx_reg, abs_dx_next;
    logic [COORD_BITS-1:0]  abs_dy_reg, abs_dy_next;
    logic [COORD_BITS-1:0]  major_len_reg, major_len_next;
    dir_t                   dir_x_reg, dir_x_next;
    dir_t                   dir_y_reg, dir_y_next;
    logic [SCOORD_BITS-1:0] pixels_left_reg, pixels_left_next;
    logic                   busy_reg, busy_next;
    logic [15:0]            held_color_reg, held_color_next;

    // pipeline
    logic  s1_valid_reg, s1_valid_next;
    req_t  s1_reg;
    logic  s2_valid_reg, s2_valid_next;
    map_t  s2_reg, s2_next;
    logic  pix_valid_reg, pix_valid_next;
    logic [ADDR_BITS-1:0] pixel_addr_reg, pixel_addr_next;
    logic [15:0]          pixel_color_reg;
    logic                 off_panel_reg, off_panel_next;
    logic                 last_pixel_reg;

    logic req_accept;
    logic s1_emit, s1_fire, s1_ready;
    logic s2_fire, s2_ready, s3_ready;

    // stepping and mapping
    logic [SCOORD_BITS:0]   err_sum_x, err_sum_y, err_red_x, err_red_y;
    logic                   step_x, step_y;
    logic [SCOORD_BITS:0]   x_wide, y_wide, px_w, py_w;
    logic [SCOORD_BITS:0]   pw_wide, ph_wide;
    logic                   map_off, last_w;
    logic [COORD_BITS-1:0]  st_dx, st_dy, st_major;

    // address
    logic [ACC_BITS-1:0]    addr_full;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orientation_reg  <= ORIENT_RESET;
            panel_width_reg  <= WIDTH_RESET;
            panel_height_reg <= HEIGHT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_ORIENTATION:  orientation_reg  <= pwdata[0];
                REG_PANEL_WIDTH:  panel_width_reg  <= pwdata[COORD_BITS-1:0];
                REG_PANEL_HEIGHT: panel_height_reg <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_ORIENTATION:  prdata = PDATA_BITS'(orientation_reg);
            REG_PANEL_WIDTH:  prdata = PDATA_BITS'(panel_width_reg);
            REG_PANEL_HEIGHT: prdata = PDATA_BITS'(panel_height_reg);
            default:          prdata = '0;
        endcase
    end

    // ---------------- handshake ----------------
    assign s3_ready   = !pix_valid_reg || !pix_stall;
    assign s2_fire    = s2_valid_reg && s3_ready;
    assign s2_ready   = !s2_valid_reg || s2_fire;
    assign s1_emit    = (s1_reg.cmd == CMD_STEP) && busy_reg;
    // starts and idle steps leave without needing room downstream
    assign s1_fire    = s1_valid_reg && (!s1_emit || s2_ready);
    assign s1_ready   = !s1_valid_reg || s1_fire;
    assign req_stall  = !s1_ready;
    assign req_accept = req_valid && !req_stall;

    assign s1_valid_next  = req_accept || (s1_valid_reg && !s1_fire);
    assign s2_valid_next  = (s1_fire && s1_emit) || (s2_valid_reg && !s2_fire);
    assign pix_valid_next = s2_fire || (pix_valid_reg && !s3_ready);

    // ---------------- stepping ----------------
    always_comb
    begin
        err_sum_x = {1'b0, err_x_reg} + (SCOORD_BITS+1)'(abs_dx_reg);
        err_sum_y = {1'b0, err_y_reg} + (SCOORD_BITS+1)'(abs_dy_reg);
        err_red_x = err_sum_x - (SCOORD_BITS+1)'(major_len_reg);
        err_red_y = err_sum_y - (SCOORD_BITS+1)'(major_len_reg);
        step_x    = err_sum_x > (SCOORD_BITS+1)'(major_len_reg);
        step_y    = err_sum_y > (SCOORD_BITS+1)'(major_len_reg);
        last_w    = pixels_left_reg <= SCOORD_BITS'(1);

        st_dx    = (s1_reg.x_end >= s1_reg.x_start) ? s1_reg.x_end - s1_reg.x_start
                                                    : s1_reg.x_start - s1_reg.x_end;
        st_dy    = (s1_reg.y_end >= s1_reg.y_start) ? s1_reg.y_end - s1_reg.y_start
                                                    : s1_reg.y_start - s1_reg.y_end;
        st_major = (st_dx > st_dy) ? st_dx : st_dy;

        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        err_x_next       = err_x_reg;
        err_y_next       = err_y_reg;
        abs_dx_next      = abs_dx_reg;
        abs_dy_next      = abs_dy_reg;
        major_len_next   = major_len_reg;
        dir_x_next       = dir_x_reg;
        dir_y_next       = dir_y_reg;
        pixels_left_next = pixels_left_reg;
        busy_next        = busy_reg;
        held_color_next  = held_color_reg;

        if (s1_fire)
        begin
            if (s1_reg.cmd == CMD_START)
            begin
                abs_dx_next      = st_dx;
                abs_dy_next      = st_dy;
                major_len_next   = st_major;
                dir_x_next       = (s1_reg.x_end > s1_reg.x_start) ? DIR_PLUS :
                                   (s1_reg.x_end < s1_reg.x_start) ? DIR_MINUS : DIR_NONE;
                dir_y_next       = (s1_reg.y_end > s1_reg.y_start) ? DIR_PLUS :
                                   (s1_reg.y_end < s1_reg.y_start) ? DIR_MINUS : DIR_NONE;
                cur_x_next       = SCOORD_BITS'(s1_reg.x_start);
                cur_y_next       = SCOORD_BITS'(s1_reg.y_start);
                err_x_next       = '0;
                err_y_next       = '0;
                pixels_left_next = SCOORD_BITS'(st_major) + SCOORD_BITS'(2);
                held_color_next  = s1_reg.color;
                busy_next        = 1'b1;
            end
            else if (busy_reg)
            begin
                err_x_next = step_x ? err_red_x[SCOORD_BITS-1:0] : err_sum_x[SCOORD_BITS-1:0];
                err_y_next = step_y ? err_red_y[SCOORD_BITS-1:0] : err_sum_y[SCOORD_BITS-1:0];
                if (step_x)
                    cur_x_next = advance(cur_x_reg, dir_x_reg);
                if (step_y)
                    cur_y_next = advance(cur_y_reg, dir_y_reg);
                if (last_w)
                begin
                    pixels_left_next = '0;
                    busy_next        = 1'b0;
                end
                else
                    pixels_left_next = pixels_left_reg - SCOORD_BITS'(1);
            end
        end
    end

    // ---------------- orientation mapping ----------------
    always_comb
    begin
        x_wide  = {cur_x_reg[SCOORD_BITS-1], cur_x_reg};
        y_wide  = {cur_y_reg[SCOORD_BITS-1], cur_y_reg};
        pw_wide = {2'b00, panel_width_reg};
        ph_wide = {2'b00, panel_height_reg};
        if (orientation_reg == ORIENT_PORTRAIT)
        begin
            px_w = y_wide;
            py_w = ph_wide - x_wide - (SCOORD_BITS+1)'(1);
        end
        else
        begin
            px_w = x_wide;
            py_w = y_wide;
        end
        map_off = px_w[SCOORD_BITS] || py_w[SCOORD_BITS]
               || ($signed(px_w) >= $signed(pw_wide))
               || ($signed(py_w) >= $signed(ph_wide));

        s2_next.px    = px_w[COORD_BITS-1:0];
        s2_next.py    = py_w[COORD_BITS-1:0];
        s2_next.off   = map_off;
        s2_next.last  = last_w;
        s2_next.color = held_color_reg;
    end

    // ---------------- address ----------------
    always_comb
    begin
        addr_full = ACC_BITS'(s2_reg.py) * ACC_BITS'(panel_width_reg)
                  + ACC_BITS'(s2_reg.px);
        off_panel_next  = s2_reg.off || (addr_full > ADDR_MAX);
        pixel_addr_next = off_panel_next ? '0 : addr_full[ADDR_BITS-1:0];
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            pix_valid_reg   <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            err_x_reg       <= '0;
            err_y_reg       <= '0;
            abs_dx_reg      <= '0;
            abs_dy_reg      <= '0;
            major_len_reg   <= '0;
            dir_x_reg       <= DIR_NONE;
            dir_y_reg       <= DIR_NONE;
            pixels_left_reg <= '0;
            busy_reg        <= 1'b0;
            held_color_reg  <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            s2_valid_reg    <= s2_valid_next;
            pix_valid_reg   <= pix_valid_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            err_x_reg       <= err_x_next;
            err_y_reg       <= err_y_next;
            abs_dx_reg      <= abs_dx_next;
            abs_dy_reg      <= abs_dy_next;
            major_len_reg   <= major_len_next;
            dir_x_reg       <= dir_x_next;
            dir_y_reg       <= dir_y_next;
            pixels_left_reg <= pixels_left_next;
            busy_reg        <= busy_next;
            held_color_reg  <= held_color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_reg.cmd     <= cmd;
            s1_reg.x_start <= x_start;
            s1_reg.y_start <= y_start;
            s1_reg.x_end   <= x_end;
            s1_reg.y_end   <= y_end;
            s1_reg.color   <= line_color;
        end
        if (s1_fire && s1_emit)
            s2_reg <= s2_next;
        if (s2_fire)
        begin
            pixel_addr_reg  <= pixel_addr_next;
            pixel_color_reg <= s2_reg.color;
            off_panel_reg   <= off_panel_next;
            last_pixel_reg  <= s2_reg.last;
        end
    end

    assign pix_valid   = pix_valid_reg;
    assign pixel_addr  = pixel_addr_reg;
    assign pixel_color = pixel_color_reg;
    assign off_panel   = off_panel_reg;
    assign last_pixel  = last_pixel_reg;

    // ---------------- assertions ----------------
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && s1_emit && last_w) |=> !busy_reg)
        else $error("line still busy after its last pixel");

    a_idle_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (pixels_left_reg == '0))
        else $error("pixel count left over while idle");

    a_err_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (err_x_reg <= SCOORD_BITS'(major_len_reg)) && (err_y_reg <= SCOORD_BITS'(major_len_reg)))
        else $error("error accumulator above major length");

    a_off_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (pix_valid && off_panel) |-> (pixel_addr == '0))
        else $error("off-panel pixel carries an address");

endmodule

[bench/line_pixel_rasterizer_unit_tb.sv]
// ---------------------------------------------------------------------------
// line_pixel_rasterizer_unit_tb
// Self-checking bench for the line rasterizer. Start and step requests go in
// through the request channel. A line stepper in the bench, or a directed row,
// gives each expected pixel write, checked in order on the pixel channel. Panel
// setup changes over APB between phases; sender idles and sink stalls are random.
// ---------------------------------------------------------------------------
module line_pixel_rasterizer_unit_tb
    import lpr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ADDR_BITS-1:0] addr;
        logic [15:0]          color;
        logic                 off;
        logic                 last;
    } pixel_t;

    typedef struct packed {
        logic                  cmd;
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ye;
        logic [15:0]           color;
        logic                  typed;
        logic [ADDR_BITS-1:0]  t_addr;
        logic [15:0]           t_color;
        logic                  t_off;
        logic                  t_last;
    } dir_row_t;

    localparam longint ADDR_LIMIT = (longint'(1) << ADDR_BITS) - 1;
    localparam int     PHASES     = 6;
    localparam int     PHASE_ITEMS = 150;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    logic                  cmd;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [15:0]           line_color;
    logic                  pix_valid;
    logic                  pix_stall;
    logic [ADDR_BITS-1:0]  pixel_addr;
    logic [15:0]           pixel_color;
    logic                  off_panel;
    logic                  last_pixel;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_BITS-1:0] paddr;
    logic [PDATA_BITS-1:0] pwdata;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    // line stepper state
    logic [SCOORD_BITS-1:0] ln_x, ln_y, ln_err_x, ln_err_y, ln_left;
    logic [COORD_BITS-1:0]  ln_adx, ln_ady, ln_major;
    dir_t                   ln_dir_x, ln_dir_y;
    logic                   ln_busy;
    logic [15:0]            ln_color;

    // panel setup shadow
    logic                  cfg_orient;
    logic [COORD_BITS-1:0] cfg_width;
    logic [COORD_BITS-1:0] cfg_height;

    pixel_t pending_pixels[$];
    int     pixel_errors = 0;
    int     useful_items = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     stall_hold_req = 0;

    int phase_orient[PHASES] = '{1, 0, 1, 0, 0, 1};
    int phase_width [PHASES] = '{800, 800, 1, 2047, 1, 2047};
    int phase_height[PHASES] = '{480, 480, 1, 2047, 2047, 1};

    dir_row_t directed_rows[25] = '{
        // step with nothing loaded
        '{CMD_STEP,  11'd2047, 11'd2047, 11'd2047, 11'd2047, 16'hFFFF,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        // single point: written twice
        '{CMD_START, 11'd0, 11'd0, 11'd0, 11'd0, 16'hFFFF,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b1, 22'd0, 16'hFFFF, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b1, 22'd0, 16'hFFFF, 1'b0, 1'b1},
        '{CMD_STEP,  11'd5, 11'd5, 11'd5, 11'd5, 16'h1111,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        // far corner of the default panel
        '{CMD_START, 11'd799, 11'd479, 11'd799, 11'd479, 16'h0000,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd2047, 11'd0, 11'd2047, 11'd0, 16'hFFFF,
          1'b1, 22'd383999, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd2047, 11'd0, 11'd2047, 16'hFFFF,
          1'b1, 22'd383999, 16'h0000, 1'b0, 1'b1},
        // longest line, starts off panel
        '{CMD_START, 11'd2047, 11'd2047, 11'd0, 11'd0, 16'hA5A5,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b1, 22'd0, 16'hA5A5, 1'b1, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        // restart while busy
        '{CMD_START, 11'd0, 11'd0, 11'd2047, 11'd0, 16'h5A5A,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b1, 22'd0, 16'h5A5A, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        // short line, x falling, y rising
        '{CMD_START, 11'd10, 11'd5, 11'd3, 11'd9, 16'h1234,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b1, 22'd4010, 16'h1234, 1'b0, 1'b0},
        '{CMD_STEP,  11'd1, 11'd2, 11'd3, 11'd4, 16'h0000,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd0, 11'd0, 11'd0, 11'd0, 16'h0000,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0},
        '{CMD_STEP,  11'd2047, 11'd2047, 11'd0, 11'd0, 16'hFFFF,
          1'b0, 22'd0, 16'h0000, 1'b0, 1'b0}
    };

    line_pixel_rasterizer_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .cmd         (cmd),
        .x_start     (x_start),
        .y_start     (y_start),
        .x_end       (x_end),
        .y_end       (y_end),
        .line_color  (line_color),
        .pix_valid   (pix_valid),
        .pix_stall   (pix_stall),
        .pixel_addr  (pixel_addr),
        .pixel_color (pixel_color),
        .off_panel   (off_panel),
        .last_pixel  (last_pixel),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [SCOORD_BITS-1:0] move_coord(input logic [SCOORD_BITS-1:0] c,
                                                          input dir_t d);
        if (d == DIR_PLUS)
            return c + 1'b1;
        if (d == DIR_MINUS)
            return c - 1'b1;
        return c;
    endfunction

    // Advances the line stepper by one request; returns 1 when a pixel is due.
    function automatic bit rasterize(input req_t r, output pixel_t p);
        int              sx, sy, mx, my, pw, ph;
        longint          a;
        logic [SCOORD_BITS:0] ex, ey;
        p = '0;
        if (r.cmd == CMD_START)
        begin
            ln_adx   = (r.x_end >= r.x_start) ? r.x_end - r.x_start : r.x_start - r.x_end;
            ln_ady   = (r.y_end >= r.y_start) ? r.y_end - r.y_start : r.y_start - r.y_end;
            ln_dir_x = (r.x_end > r.x_start) ? DIR_PLUS :
                       (r.x_end < r.x_start) ? DIR_MINUS : DIR_NONE;
            ln_dir_y = (r.y_end > r.y_start) ? DIR_PLUS :
                       (r.y_end < r.y_start) ? DIR_MINUS : DIR_NONE;
            ln_major = (ln_adx > ln_ady) ? ln_adx : ln_ady;
            ln_x     = {1'b0, r.x_start};
            ln_y     = {1'b0, r.y_start};
            ln_err_x = '0;
            ln_err_y = '0;
            ln_left  = {1'b0, ln_major} + 12'd2;
            ln_color = r.color;
            ln_busy  = 1'b1;
            return 1'b0;
        end
        if (!ln_busy)
            return 1'b0;

        sx = $signed(ln_x);
        sy = $signed(ln_y);
        pw = cfg_width;
        ph = cfg_height;
        if (cfg_orient == ORIENT_PORTRAIT)
        begin
            mx = sy;
            my = ph - sx - 1;
        end
        else
        begin
            mx = sx;
            my = sy;
        end
        if (mx < 0 || mx >= pw || my < 0 || my >= ph)
            p.off = 1'b1;
        else
        begin
            a = longint'(pw) * longint'(my) + longint'(mx);
            if (a > ADDR_LIMIT)
                p.off = 1'b1;
            else
                p.addr = a[ADDR_BITS-1:0];
        end
        p.color = ln_color;
        p.last  = (ln_left <= 12'd1);

        ex = {1'b0, ln_err_x} + ln_adx;
        ey = {1'b0, ln_err_y} + ln_ady;
        if (ex > ln_major)
        begin
            ex   = ex - ln_major;
            ln_x = move_coord(ln_x, ln_dir_x);
        end
        if (ey > ln_major)
        begin
            ey   = ey - ln_major;
            ln_y = move_coord(ln_y, ln_dir_y);
        end
        ln_err_x = ex[SCOORD_BITS-1:0];
        ln_err_y = ey[SCOORD_BITS-1:0];

        if (p.last)
        begin
            ln_left = '0;
            ln_busy = 1'b0;
        end
        else
            ln_left = ln_left - 1'b1;
        return 1'b1;
    endfunction

    function automatic logic [COORD_BITS-1:0] fit_coord(input int v);
        if (v < 0)
            return '0;
        if (v > 2047)
            return COORD_BITS'(2047);
        return COORD_BITS'(v);
    endfunction

    // mostly near the origin or a panel edge, sometimes anywhere
    function automatic logic [COORD_BITS-1:0] pick_coord(input int edge_pos);
        case ($urandom_range(2))
            0:       return COORD_BITS'($urandom_range(31));
            1:       return fit_coord(edge_pos + int'($urandom_range(32)) - 16);
            default: return COORD_BITS'($urandom_range(2047));
        endcase
    endfunction

    function automatic req_t random_req(input logic c);
        req_t r;
        r.cmd     = c;
        r.x_start = COORD_BITS'($urandom);
        r.y_start = COORD_BITS'($urandom);
        r.x_end   = COORD_BITS'($urandom);
        r.y_end   = COORD_BITS'($urandom);
        r.color   = 16'($urandom);
        return r;
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic issue_request(input req_t r, input bit use_typed, input pixel_t typed_px);
        pixel_t px;
        bit     due;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        req_valid  <= 1'b1;
        cmd        <= r.cmd;
        x_start    <= r.x_start;
        y_start    <= r.y_start;
        x_end      <= r.x_end;
        y_end      <= r.y_end;
        line_color <= r.color;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        due = rasterize(r, px);
        if (due)
            pending_pixels.push_back(use_typed ? typed_px : px);
        if (due || r.cmd == CMD_START)
            useful_items++;
    endtask

    task automatic drain_pixels();
        req_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        // a trailing start may still sit in the pipeline
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [PDATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ORIENTATION:  cfg_orient = value[0];
            REG_PANEL_WIDTH:  cfg_width  = value[COORD_BITS-1:0];
            REG_PANEL_HEIGHT: cfg_height = value[COORD_BITS-1:0];
            default: ;
        endcase
    endtask

    // Well-formed lines with random content, plus some stray requests.
    task automatic draw_lines(input int item_goal);
        req_t   r;
        pixel_t none;
        int     edge_x, edge_y, dx, dy, steps;
        none = '0;
        while (useful_items < item_goal)
        begin
            if ($urandom_range(19) == 0)
            begin
                issue_request(random_req(1'($urandom_range(1))), 1'b0, none);
                continue;
            end
            edge_x = (cfg_orient == ORIENT_PORTRAIT) ? cfg_height : cfg_width;
            edge_y = (cfg_orient == ORIENT_PORTRAIT) ? cfg_width : cfg_height;
            r = random_req(CMD_START);
            r.x_start = pick_coord(edge_x);
            r.y_start = pick_coord(edge_y);
            if ($urandom_range(4) != 0)
            begin
                r.x_end = fit_coord(int'(r.x_start) + int'($urandom_range(32)) - 16);
                r.y_end = fit_coord(int'(r.y_start) + int'($urandom_range(32)) - 16);
            end
            issue_request(r, 1'b0, none);
            dx = (r.x_end > r.x_start) ? r.x_end - r.x_start : r.x_start - r.x_end;
            dy = (r.y_end > r.y_start) ? r.y_end - r.y_start : r.y_start - r.y_end;
            steps = ((dx > dy) ? dx : dy) + 2;
            if (steps > 70)
                steps = $urandom_range(60, 1);
            case ($urandom_range(9))
                7:       steps = $urandom_range(steps);
                8, 9:    steps = steps + $urandom_range(2, 1);
                default: ;
            endcase
            repeat (steps)
                issue_request(random_req(CMD_STEP), 1'b0, none);
            // now and then let the pipeline run dry
            if ($urandom_range(29) == 0)
                drain_pixels();
        end
    endtask

    // pixel sink
    initial
    begin
        int hold_left;
        hold_left = 0;
        pix_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_hold_req > 0)
            begin
                hold_left      = stall_hold_req;
                stall_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                pix_stall <= 1'b1;
                hold_left--;
            end
            else
                pix_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : pixel_check
        pixel_t want;
        if (rst_n === 1'b1 && pix_valid === 1'b1 && pix_stall === 1'b0)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: pixel with none pending: addr %0d color %h off %b last %b",
                         $time, pixel_addr, pixel_color, off_panel, last_pixel);
                pixel_errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_addr !== want.addr)
                begin
                    $display("%0t: pixel_addr expected %0d actual %0d",
                             $time, want.addr, pixel_addr);
                    pixel_errors++;
                end
                if (pixel_color !== want.color)
                begin
                    $display("%0t: pixel_color expected %h actual %h",
                             $time, want.color, pixel_color);
                    pixel_errors++;
                end
                if (off_panel !== want.off)
                begin
                    $display("%0t: off_panel expected %b actual %b",
                             $time, want.off, off_panel);
                    pixel_errors++;
                end
                if (last_pixel !== want.last)
                begin
                    $display("%0t: last_pixel expected %b actual %b",
                             $time, want.last, last_pixel);
                    pixel_errors++;
                end
            end
        end
    end

    initial
    begin
        req_t   r;
        pixel_t typed_px;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        cmd        = CMD_START;
        x_start    = '0;
        y_start    = '0;
        x_end      = '0;
        y_end      = '0;
        line_color = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        cfg_orient = ORIENT_RESET;
        cfg_width  = WIDTH_RESET;
        cfg_height = HEIGHT_RESET;
        ln_x = '0; ln_y = '0; ln_err_x = '0; ln_err_y = '0; ln_left = '0;
        ln_adx = '0; ln_ady = '0; ln_major = '0;
        ln_dir_x = DIR_NONE; ln_dir_y = DIR_NONE;
        ln_busy = 1'b0; ln_color = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 7;
        recv_stall_pct = 71;
        foreach (directed_rows[i])
        begin
            r.cmd          = directed_rows[i].cmd;
            r.x_start      = directed_rows[i].xs;
            r.y_start      = directed_rows[i].ys;
            r.x_end        = directed_rows[i].xe;
            r.y_end        = directed_rows[i].ye;
            r.color        = directed_rows[i].color;
            typed_px.addr  = directed_rows[i].t_addr;
            typed_px.color = directed_rows[i].t_color;
            typed_px.off   = directed_rows[i].t_off;
            typed_px.last  = directed_rows[i].t_last;
            issue_request(r, directed_rows[i].typed, typed_px);
        end
        drain_pixels();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // reset panel setup is kept for the first phase
            if (ph > 0)
            begin
                write_register(REG_ORIENTATION, PDATA_BITS'(phase_orient[ph]));
                write_register(REG_PANEL_WIDTH, PDATA_BITS'(phase_width[ph]));
                write_register(REG_PANEL_HEIGHT, PDATA_BITS'(phase_height[ph]));
            end
            case (ph / 2)
                0:
                begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 71;
                end
                1:
                begin
                    send_idle_pct  = 71;
                    recv_stall_pct = 7;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            // long sink hold-off so the pipeline fills and backs up the requests
            if (ph == 4)
                stall_hold_req = 200;
            draw_lines(useful_items + PHASE_ITEMS);
            drain_pixels();
        end

        repeat (10) @(posedge clk);
        if (pixel_errors == 0)
            $display("line_pixel_rasterizer_unit_tb: PASS");
        else
            $display("line_pixel_rasterizer_unit_tb: FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("line_pixel_rasterizer_unit_tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
src/lpr_pkg.sv
src/line_pixel_rasterizer_unit.sv
bench/line_pixel_rasterizer_unit_tb.sv
